[design/assert_macros.svh]
// assertion helper macros used by the top-level design file
// expects a clock clk_i and an active-low reset rst_ni in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define FCDT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fcdt assertion failed");

// next-cycle implication, checked outside reset
`define FCDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fcdt assertion failed");

`endif

[design/fcdt_pkg.sv]
// shared types, constants and helpers for the foot contact debounce tracker
// no dependencies; used by fcdt_leg_unit and foot_contact_debounce_tracker
package fcdt_pkg;

  // sizes
  localparam int unsigned NUM_LEGS   = 6;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned LEG_CNT_W  = (NUM_LEGS > 1) ? $clog2(NUM_LEGS) : 1;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned CONF_W     = 16;
  localparam int unsigned STREAK_W   = 8;
  localparam int unsigned DEB_W      = 8;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned US_W       = 26;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned LEG_IDX_W  = 3;
  localparam int unsigned MM_W       = 3;

  // milliseconds to microseconds
  localparam logic [US_W-1:0] MS_TO_US = US_W'(1000);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TD_WINDOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd2;

  // contact phases
  localparam logic [PHASE_W-1:0] PH_SEARCH = 3'd0;
  localparam logic [PHASE_W-1:0] PH_EXPECT = 3'd1;
  localparam logic [PHASE_W-1:0] PH_CAND   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_STANCE = 3'd3;
  localparam logic [PHASE_W-1:0] PH_LOST   = 3'd4;

  // confidence constants, 32768 = 1.0
  localparam logic [CONF_W-1:0] CONF_ONE        = 16'd32768;
  localparam logic [CONF_W-1:0] RISE_MEAS       = 16'd7209;
  localparam logic [CONF_W-1:0] RISE_PRED       = 16'd4588;
  localparam logic [CONF_W-1:0] DECAY_MEAS      = 16'd3277;
  localparam logic [CONF_W-1:0] DECAY_PRED      = 16'd4588;
  localparam logic [CONF_W-1:0] HOLD_DECAY_MEAS = 16'd1147;
  localparam logic [CONF_W-1:0] HOLD_DECAY_PRED = 16'd1606;
  localparam logic [CONF_W-1:0] FLOOR_STANCE    = 16'd26214;
  localparam logic [CONF_W-1:0] FLOOR_CAND      = 16'd15729;
  localparam logic [CONF_W-1:0] FLOOR_EXPECT    = 16'd10486;
  localparam logic [CONF_W-1:0] FLOOR_LOST      = 16'd6554;
  localparam logic [CONF_W-1:0] FLOOR_SEARCH    = 16'd1638;

  // input request
  typedef struct packed {
    logic [TIME_W-1:0]   sample_time_us;
    logic [NUM_LEGS-1:0] raw_contacts;
    logic                mode;
  } fcdt_in_t;

  // one per-leg result
  typedef struct packed {
    logic [LEG_IDX_W-1:0] leg_index;
    logic [PHASE_W-1:0]   phase;
    logic [CONF_W-1:0]    confidence;
    logic                 stance_flag;
    logic                 mismatch;
    logic [MM_W-1:0]      mismatch_total;
    logic                 last;
  } fcdt_out_t;

  // stored state of one leg
  typedef struct packed {
    logic [PHASE_W-1:0]  phase;
    logic [CONF_W-1:0]   conf;
    logic [STREAK_W-1:0] streak;
    logic [TIME_W-1:0]   deadline;
  } fcdt_leg_t;

  // per-sample context shared by all legs
  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [US_W-1:0]   td_us;
    logic [US_W-1:0]   hold_us;
    logic [DEB_W-1:0]  deb;
    logic              pred;
    logic              prev;
  } fcdt_ctx_t;

  // confidence floor per phase, unknown codes act as search
  function automatic logic [CONF_W-1:0] floor_of(input logic [PHASE_W-1:0] ph);
    logic [CONF_W-1:0] fl;
    case (ph)
      PH_STANCE: fl = FLOOR_STANCE;
      PH_CAND:   fl = FLOOR_CAND;
      PH_EXPECT: fl = FLOOR_EXPECT;
      PH_LOST:   fl = FLOOR_LOST;
      default:   fl = FLOOR_SEARCH;
    endcase
    return fl;
  endfunction

endpackage

[design/fcdt_leg_unit.sv]
// shared per-leg update unit: phase machine, streak, deadline and confidence
// depends on fcdt_pkg; used once per leg per sample by the top level
module fcdt_leg_unit (
  input  fcdt_pkg::fcdt_ctx_t ctx_i,
  input  logic                contact_i,
  input  fcdt_pkg::fcdt_leg_t leg_i,
  output fcdt_pkg::fcdt_leg_t leg_o,
  output logic                mismatch_o
);

  localparam logic [1:0] CM_ONE   = 2'd0;
  localparam logic [1:0] CM_RISE  = 2'd1;
  localparam logic [1:0] CM_DECAY = 2'd2;
  localparam logic [1:0] CM_HOLD  = 2'd3;

  logic [fcdt_pkg::PHASE_W-1:0]  ph_cur;
  logic [fcdt_pkg::PHASE_W-1:0]  ph_new;
  logic [fcdt_pkg::STREAK_W-1:0] streak_inc;
  logic [fcdt_pkg::STREAK_W-1:0] streak_new;
  logic [fcdt_pkg::DEB_W-1:0]    deb_eff;
  logic                          was_stance;
  logic                          window_open;
  logic                          expired;
  logic                          use_hold;
  logic                          set_dl;
  logic                          clear_dl;
  logic [1:0]                    conf_mode;
  logic [fcdt_pkg::US_W-1:0]     window_us;
  logic [fcdt_pkg::TIME_W:0]     dl_sum;
  logic [fcdt_pkg::TIME_W-1:0]   dl_add;
  logic [fcdt_pkg::TIME_W-1:0]   dl_new;
  logic [fcdt_pkg::CONF_W-1:0]   fl;
  logic [fcdt_pkg::CONF_W-1:0]   rise;
  logic [fcdt_pkg::CONF_W-1:0]   dec;
  logic [fcdt_pkg::CONF_W-1:0]   base;
  logic [fcdt_pkg::CONF_W:0]     rise_sum;
  logic [fcdt_pkg::CONF_W-1:0]   dec_diff;
  logic [fcdt_pkg::CONF_W-1:0]   conf_raw;
  logic [fcdt_pkg::CONF_W-1:0]   conf_new;

  // phase and streak decisions
  always_comb begin
    ph_cur      = (leg_i.phase > fcdt_pkg::PH_LOST) ? fcdt_pkg::PH_SEARCH : leg_i.phase;
    was_stance  = (ph_cur == fcdt_pkg::PH_STANCE);
    window_open = (leg_i.deadline != '0) && (ctx_i.now <= leg_i.deadline);
    expired     = (leg_i.deadline != '0) && (ctx_i.now > leg_i.deadline);
    streak_inc  = (leg_i.streak == '1) ? leg_i.streak :
                  leg_i.streak + fcdt_pkg::STREAK_W'(1);
    deb_eff     = (ctx_i.deb == '0) ? fcdt_pkg::DEB_W'(1) : ctx_i.deb;
    ph_new      = ph_cur;
    streak_new  = '0;
    use_hold    = 1'b0;
    set_dl      = 1'b0;
    clear_dl    = 1'b0;
    conf_mode   = CM_DECAY;
    if (contact_i && !ctx_i.prev) begin
      // no usable previous sample: straight to stance
      ph_new     = fcdt_pkg::PH_STANCE;
      streak_new = fcdt_pkg::STREAK_W'(1);
      use_hold   = 1'b1;
      set_dl     = 1'b1;
      conf_mode  = CM_ONE;
    end else if (contact_i) begin
      streak_new = streak_inc;
      set_dl     = 1'b1;
      conf_mode  = CM_RISE;
      if (!was_stance && streak_inc == fcdt_pkg::STREAK_W'(1)) begin
        ph_new = fcdt_pkg::PH_EXPECT;
      end else if (!was_stance && streak_inc < deb_eff) begin
        ph_new = fcdt_pkg::PH_CAND;
      end else begin
        ph_new   = fcdt_pkg::PH_STANCE;
        use_hold = 1'b1;
      end
    end else if (was_stance) begin
      if (window_open) begin
        conf_mode = CM_HOLD;
      end else begin
        ph_new = fcdt_pkg::PH_LOST;
        set_dl = 1'b1;
      end
    end else if (ph_cur == fcdt_pkg::PH_CAND || ph_cur == fcdt_pkg::PH_EXPECT ||
                 ph_cur == fcdt_pkg::PH_LOST) begin
      if (expired) begin
        ph_new   = fcdt_pkg::PH_SEARCH;
        clear_dl = 1'b1;
      end
    end else begin
      ph_new   = fcdt_pkg::PH_SEARCH;
      clear_dl = 1'b1;
    end
  end

  // deadline adder, saturating at the top of the time range
  assign window_us = use_hold ? ctx_i.hold_us : ctx_i.td_us;
  assign dl_sum    = {1'b0, ctx_i.now} + (fcdt_pkg::TIME_W + 1)'(window_us);
  assign dl_add    = dl_sum[fcdt_pkg::TIME_W] ? '1 : dl_sum[fcdt_pkg::TIME_W-1:0];

  always_comb begin
    if (set_dl) begin
      dl_new = dl_add;
    end else if (clear_dl) begin
      dl_new = '0;
    end else begin
      dl_new = leg_i.deadline;
    end
  end

  // confidence rise, decay and clamp
  assign fl       = fcdt_pkg::floor_of(ph_new);
  assign rise     = ctx_i.pred ? fcdt_pkg::RISE_PRED : fcdt_pkg::RISE_MEAS;
  assign dec      = (conf_mode == CM_HOLD) ?
                    (ctx_i.pred ? fcdt_pkg::HOLD_DECAY_PRED : fcdt_pkg::HOLD_DECAY_MEAS) :
                    (ctx_i.pred ? fcdt_pkg::DECAY_PRED : fcdt_pkg::DECAY_MEAS);
  assign base     = (leg_i.conf < fl) ? fl : leg_i.conf;
  assign rise_sum = {1'b0, base} + {1'b0, rise};
  assign dec_diff = (leg_i.conf > dec) ? leg_i.conf - dec : '0;

  always_comb begin
    case (conf_mode)
      CM_ONE:  conf_raw = fcdt_pkg::CONF_ONE;
      CM_RISE: conf_raw = (rise_sum > {1'b0, fcdt_pkg::CONF_ONE}) ?
                          fcdt_pkg::CONF_ONE : rise_sum[fcdt_pkg::CONF_W-1:0];
      default: conf_raw = dec_diff;
    endcase
    conf_new = (conf_raw < fl) ? fl : conf_raw;
    if (conf_new > fcdt_pkg::CONF_ONE) begin
      conf_new = fcdt_pkg::CONF_ONE;
    end
  end

  // updated leg state
  always_comb begin
    leg_o.phase    = ph_new;
    leg_o.conf     = conf_new;
    leg_o.streak   = streak_new;
    leg_o.deadline = dl_new;
    mismatch_o     = contact_i != (ph_new == fcdt_pkg::PH_STANCE);
  end

endmodule

[design/foot_contact_debounce_tracker.sv]
// top level of the foot contact debounce tracker: sequencer, leg state, result register
// depends on fcdt_pkg, fcdt_leg_unit and assert_macros.svh
//
//   channel   signals                               direction
//   in        in_valid_i/in_ready_o, in_data_i      sample request in
//   out       out_valid_o/out_ready_i, out_data_o   one result per leg out
//   cfg       cfg_valid_i/cfg_ready_o, cfg_index_i,  register write in
//             cfg_data_i
//
// a sample is taken into the context registers, then the shared leg unit updates one leg per
// cycle while the result register is not stalled.
// a stalled result register holds the sequencer on the current leg.
// reset sets every leg to search with zero confidence, streak and deadline.
// config writes are always taken; milliseconds are scaled to microseconds on write.
`include "assert_macros.svh"

module foot_contact_debounce_tracker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  fcdt_pkg::fcdt_in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output fcdt_pkg::fcdt_out_t                  out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fcdt_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fcdt_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                           state_q, state_d;
  logic [fcdt_pkg::LEG_CNT_W-1:0] leg_q, leg_d;
  logic                           have_prev_q;
  fcdt_pkg::fcdt_ctx_t            ctx_q;
  logic [fcdt_pkg::NUM_LEGS-1:0]  raw_q;
  logic [fcdt_pkg::MM_W-1:0]      mm_cnt_q, mm_cnt_d;
  logic [fcdt_pkg::US_W-1:0]      td_us_q;
  logic [fcdt_pkg::US_W-1:0]      hold_us_q;
  logic [fcdt_pkg::DEB_W-1:0]     deb_q;
  fcdt_pkg::fcdt_leg_t            legs_q [fcdt_pkg::NUM_LEGS];
  logic                           out_valid_q;
  fcdt_pkg::fcdt_out_t            out_data_q, out_data_d;

  logic                           in_fire;
  logic                           step;
  logic                           last_leg;
  logic                           contact;
  fcdt_pkg::fcdt_leg_t            leg_cur;
  fcdt_pkg::fcdt_leg_t            leg_upd;
  logic                           leg_mm;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign step        = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);
  assign last_leg    = (leg_q == fcdt_pkg::LEG_CNT_W'(fcdt_pkg::NUM_LEGS - 1));
  assign contact     = raw_q[leg_q];
  assign leg_cur     = legs_q[leg_q];
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // shared leg update unit
  fcdt_leg_unit u_leg (
    .ctx_i      (ctx_q),
    .contact_i  (contact),
    .leg_i      (leg_cur),
    .leg_o      (leg_upd),
    .mismatch_o (leg_mm)
  );

  // sequencer next state
  always_comb begin
    state_d  = state_q;
    leg_d    = leg_q;
    mm_cnt_d = mm_cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d  = ST_RUN;
          leg_d    = '0;
          mm_cnt_d = '0;
        end
      end
      ST_RUN: begin
        if (step) begin
          mm_cnt_d = mm_cnt_q + fcdt_pkg::MM_W'(leg_mm);
          if (last_leg) begin
            state_d = ST_IDLE;
          end else begin
            leg_d = leg_q + fcdt_pkg::LEG_CNT_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result for the current leg
  always_comb begin
    out_data_d.leg_index      = fcdt_pkg::LEG_IDX_W'(leg_q);
    out_data_d.phase          = leg_upd.phase;
    out_data_d.confidence     = leg_upd.conf;
    out_data_d.stance_flag    = (leg_upd.phase == fcdt_pkg::PH_STANCE);
    out_data_d.mismatch       = leg_mm;
    out_data_d.mismatch_total = last_leg ? mm_cnt_q + fcdt_pkg::MM_W'(leg_mm) : '0;
    out_data_d.last           = last_leg;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      leg_q       <= '0;
      mm_cnt_q    <= '0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      leg_q    <= leg_d;
      mm_cnt_q <= mm_cnt_d;
      if (in_fire) begin
        have_prev_q <= (in_data_i.sample_time_us != '0);
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // configuration registers, windows kept in microseconds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      td_us_q   <= '0;
      hold_us_q <= '0;
      deb_q     <= fcdt_pkg::DEB_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        fcdt_pkg::CFG_TD_WINDOW:   td_us_q   <= fcdt_pkg::US_W'(cfg_data_i) * fcdt_pkg::MS_TO_US;
        fcdt_pkg::CFG_HOLD_WINDOW: hold_us_q <= fcdt_pkg::US_W'(cfg_data_i) * fcdt_pkg::MS_TO_US;
        fcdt_pkg::CFG_DEBOUNCE:    deb_q     <= cfg_data_i[fcdt_pkg::DEB_W-1:0];
        default: ;
      endcase
    end
  end

  // per-leg state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fcdt_pkg::NUM_LEGS; i++) begin
        legs_q[i].phase    <= fcdt_pkg::PH_SEARCH;
        legs_q[i].conf     <= '0;
        legs_q[i].streak   <= '0;
        legs_q[i].deadline <= '0;
      end
    end else if (step) begin
      legs_q[leg_q] <= leg_upd;
    end
  end

  // sample context and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ctx_q.now     <= in_data_i.sample_time_us;
      ctx_q.td_us   <= td_us_q;
      ctx_q.hold_us <= hold_us_q;
      ctx_q.deb     <= deb_q;
      ctx_q.pred    <= in_data_i.mode;
      ctx_q.prev    <= have_prev_q;
      raw_q         <= in_data_i.raw_contacts;
    end
    if (step) begin
      out_data_q <= out_data_d;
    end
  end

  // checks
  `FCDT_ASSERT_NEXT(a_start_at_leg0, in_valid_i && in_ready_o,
                    !in_ready_o && leg_q == '0)
  `FCDT_ASSERT_NOW(a_conf_in_range, out_valid_o,
                   out_data_o.confidence >= fcdt_pkg::floor_of(out_data_o.phase) &&
                   out_data_o.confidence <= fcdt_pkg::CONF_ONE)
  `FCDT_ASSERT_NOW(a_last_on_final_leg, out_valid_o && out_data_o.last,
                   out_data_o.leg_index == fcdt_pkg::LEG_IDX_W'(fcdt_pkg::NUM_LEGS - 1))
  `FCDT_ASSERT_NOW(a_total_only_on_last, out_valid_o && !out_data_o.last,
                   out_data_o.mismatch_total == '0)

endmodule

[sim/fcdt_contact_checker.sv]
// checker for the foot contact debounce tracker: per-leg contact prediction and result compare
// watches the sample, result and register channels; depends on fcdt_pkg only
module fcdt_contact_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  fcdt_pkg::fcdt_in_t              in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  fcdt_pkg::fcdt_out_t             out_data_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [fcdt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fcdt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              error_count_o,
  output int                              pending_o,
  output int                              results_checked_o,
  output logic [7:0]                      phases_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import fcdt_pkg::*;

  localparam logic [TIME_W-1:0] TIME_MAX   = '1;
  localparam int unsigned       STREAK_MAX = 255;

  // register copies
  logic [MS_W-1:0]  td_ms;
  logic [MS_W-1:0]  hold_ms;
  logic [DEB_W-1:0] deb_cfg;

  // per-leg contact state
  logic [PHASE_W-1:0]  leg_phase    [NUM_LEGS];
  logic [CONF_W-1:0]   leg_conf     [NUM_LEGS];
  logic [STREAK_W-1:0] leg_streak   [NUM_LEGS];
  logic [TIME_W-1:0]   leg_deadline [NUM_LEGS];
  logic                prev_seen;

  // leg results still owed by the block, oldest first
  fcdt_out_t expected_legs_q[$];

  // confidence floor for a phase, unknown codes count as search
  function automatic int unsigned phase_floor(input logic [PHASE_W-1:0] ph);
    int unsigned fl;
    case (ph)
      PH_STANCE: fl = FLOOR_STANCE;
      PH_CAND:   fl = FLOOR_CAND;
      PH_EXPECT: fl = FLOOR_EXPECT;
      PH_LOST:   fl = FLOOR_LOST;
      default:   fl = FLOOR_SEARCH;
    endcase
    return fl;
  endfunction

  // window end, saturating at the largest timestamp
  function automatic logic [TIME_W-1:0] window_end(input logic [TIME_W-1:0] now,
                                                   input logic [63:0] span);
    logic [63:0] room;
    room = 64'(TIME_MAX) - span;
    if (64'(now) > room) return TIME_MAX;
    return TIME_W'(64'(now) + span);
  endfunction

  // subtract a decay step, never below the floor
  function automatic int unsigned decayed(input int unsigned conf, input int unsigned step,
                                          input int unsigned fl);
    int unsigned v;
    v = (conf > step) ? conf - step : 0;
    return (v < fl) ? fl : v;
  endfunction

  task automatic clear_model();
    td_ms     = '0;
    hold_ms   = '0;
    deb_cfg   = DEB_W'(1);
    prev_seen = 1'b0;
    for (int leg = 0; leg < NUM_LEGS; leg++) begin
      leg_phase[leg]    = PH_SEARCH;
      leg_conf[leg]     = '0;
      leg_streak[leg]   = '0;
      leg_deadline[leg] = '0;
    end
  endtask

  task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_TD_WINDOW:   td_ms   = data;
      CFG_HOLD_WINDOW: hold_ms = data;
      CFG_DEBOUNCE:    deb_cfg = data[DEB_W-1:0];
      default: ;
    endcase
  endtask

  // run every leg's contact machine on one sample and queue its six results
  task automatic predict_sample(input fcdt_in_t smp);
    logic [TIME_W-1:0]  now;
    logic [TIME_W-1:0]  dl;
    logic [63:0]        td_us;
    logic [63:0]        hold_us;
    logic [PHASE_W-1:0] ph;
    logic               prev;
    logic               rc;
    logic               was_stance;
    logic               fused;
    int unsigned        deb;
    int unsigned        rise;
    int unsigned        fall;
    int unsigned        hold_fall;
    int unsigned        conf;
    int unsigned        fl;
    int unsigned        st;
    int unsigned        mism;
    fcdt_out_t          res;
    now       = smp.sample_time_us;
    prev      = prev_seen;
    td_us     = 64'(td_ms) * 64'd1000;
    hold_us   = 64'(hold_ms) * 64'd1000;
    deb       = (deb_cfg == '0) ? 1 : deb_cfg;
    rise      = smp.mode ? RISE_PRED : RISE_MEAS;
    fall      = smp.mode ? DECAY_PRED : DECAY_MEAS;
    hold_fall = smp.mode ? HOLD_DECAY_PRED : HOLD_DECAY_MEAS;
    mism      = 0;
    for (int leg = 0; leg < NUM_LEGS; leg++) begin
      ph   = leg_phase[leg];
      conf = leg_conf[leg];
      dl   = leg_deadline[leg];
      st   = leg_streak[leg];
      rc   = smp.raw_contacts[leg];
      if (ph > PH_LOST) ph = PH_SEARCH;

      if (!prev && rc) begin
        // no usable previous sample: contact is trusted at once
        ph   = PH_STANCE;
        conf = CONF_ONE;
        dl   = window_end(now, hold_us);
        st   = 1;
      end else if (rc) begin
        // contact: debounce toward stance and raise confidence
        was_stance = (ph == PH_STANCE);
        if (st < STREAK_MAX) st++;
        if (!was_stance && st == 1) begin
          ph = PH_EXPECT;
          dl = window_end(now, td_us);
        end else if (!was_stance && st < deb) begin
          ph = PH_CAND;
          dl = window_end(now, td_us);
        end else begin
          ph = PH_STANCE;
          dl = window_end(now, hold_us);
        end
        fl   = phase_floor(ph);
        conf = ((conf < fl) ? fl : conf) + rise;
        if (conf > CONF_ONE) conf = CONF_ONE;
      end else begin
        // gap: hold stance inside its window, otherwise fall back
        st = 0;
        if (ph == PH_STANCE) begin
          if (dl != '0 && now <= dl) begin
            conf = decayed(conf, hold_fall, phase_floor(PH_STANCE));
          end else begin
            ph   = PH_LOST;
            dl   = window_end(now, td_us);
            conf = decayed(conf, fall, phase_floor(ph));
          end
        end else if (ph == PH_CAND || ph == PH_EXPECT || ph == PH_LOST) begin
          if (dl != '0 && now > dl) begin
            ph = PH_SEARCH;
            dl = '0;
          end
          conf = decayed(conf, fall, phase_floor(ph));
        end else begin
          ph   = PH_SEARCH;
          dl   = '0;
          conf = decayed(conf, fall, phase_floor(ph));
        end
      end

      fl = phase_floor(ph);
      if (conf < fl) conf = fl;
      if (conf > CONF_ONE) conf = CONF_ONE;
      fused = (ph == PH_STANCE);
      if (rc != fused) mism++;

      leg_phase[leg]    = ph;
      leg_conf[leg]     = CONF_W'(conf);
      leg_streak[leg]   = STREAK_W'(st);
      leg_deadline[leg] = dl;

      res               = '0;
      res.leg_index     = LEG_IDX_W'(leg);
      res.phase         = ph;
      res.confidence    = CONF_W'(conf);
      res.stance_flag   = fused;
      res.mismatch      = (rc != fused);
      if (leg == NUM_LEGS - 1) begin
        res.mismatch_total = MM_W'(mism);
        res.last           = 1'b1;
      end
      expected_legs_q.push_back(res);
    end
    prev_seen = (now != '0);
  endtask

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    $display("%0t: leg result field %s expected %0d actual %0d", $time, name, want, got);
    error_count_o++;
  endtask

  task automatic check_result(input fcdt_out_t got);
    fcdt_out_t want;
    if (expected_legs_q.size() == 0) begin
      $display("%0t: leg result expected none actual %h", $time, got);
      error_count_o++;
    end else begin
      want = expected_legs_q.pop_front();
      if (got.leg_index !== want.leg_index)
        report_field("leg_index", want.leg_index, got.leg_index);
      if (got.phase !== want.phase)
        report_field("phase", want.phase, got.phase);
      if (got.confidence !== want.confidence)
        report_field("confidence", want.confidence, got.confidence);
      if (got.stance_flag !== want.stance_flag)
        report_field("stance_flag", want.stance_flag, got.stance_flag);
      if (got.mismatch !== want.mismatch)
        report_field("mismatch", want.mismatch, got.mismatch);
      if (got.mismatch_total !== want.mismatch_total)
        report_field("mismatch_total", want.mismatch_total, got.mismatch_total);
      if (got.last !== want.last)
        report_field("last", want.last, got.last);
      results_checked_o++;
      if (!$isunknown(got.phase)) phases_seen_o[got.phase] = 1'b1;
    end
  endtask

  // watch all three channels at the rising edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_model();
      expected_legs_q.delete();
      error_count_o     = 0;
      results_checked_o = 0;
      phases_seen_o     = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_reg_write(cfg_index_i, cfg_data_i);
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (in_valid_i && in_ready_i) predict_sample(in_data_i);
    end
    pending_o = expected_legs_q.size();
  end

endmodule

[sim/tb_foot_contact_debounce_tracker.sv]
// testbench top for the foot contact debounce tracker: clock, reset, stimulus and verdict
// depends on fcdt_pkg, foot_contact_debounce_tracker and fcdt_contact_checker
module tb_foot_contact_debounce_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import fcdt_pkg::*;

  localparam logic [TIME_W-1:0]    TIME_MAX        = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE       = 2'd3;
  localparam int                   SETTLE_CYCLES   = 2 * (NUM_LEGS + 1);
  localparam int                   PRESSURE_CYCLES = 120;
  localparam int                   CYCLE_LIMIT     = 200000;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  fcdt_in_t              in_data     = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  fcdt_out_t             out_data;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = CFG_TD_WINDOW;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  int         error_count;
  int         pending;
  int         results_checked;
  logic [7:0] phases_seen;

  int tx_idle_pct   = 13;
  int rx_idle_pct   = 67;
  int samples_sent  = 0;
  int settings_used = 0;
  int cycle_count   = 0;
  int hold_count    = 0;

  logic pressure_req  = 1'b0;
  logic pressure_done = 1'b0;

  logic [NUM_LEGS-1:0] gait_contacts = '0;
  logic [TIME_W-1:0]   gait_clock    = TIME_W'(50000);

  foot_contact_debounce_tracker i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  fcdt_contact_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .in_data_i         (in_data),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .out_data_i        (out_data),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .error_count_o     (error_count),
    .pending_o         (pending),
    .results_checked_o (results_checked),
    .phases_seen_o     (phases_seen)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles, %0d leg results still pending",
               $time, CYCLE_LIMIT, pending);
      $display("tb_foot_contact_debounce_tracker: done, errors");
      $finish;
    end
  end

  // result receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (pressure_req && !pressure_done) begin
      out_ready  <= 1'b0;
      hold_count <= hold_count + 1;
      if (hold_count == PRESSURE_CYCLES - 1) pressure_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic fcdt_in_t sample_of(input logic [TIME_W-1:0] ts,
                                         input logic [NUM_LEGS-1:0] raw, input logic mode);
    fcdt_in_t smp;
    smp.sample_time_us = ts;
    smp.raw_contacts   = raw;
    smp.mode           = mode;
    return smp;
  endfunction

  // offer one sample request, valid held until taken
  task automatic apply_sample(input fcdt_in_t smp);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data  = smp;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    samples_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // stop offering and let every owed result leave
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] td, input logic [CFG_DATA_W-1:0] hold,
                           input logic [CFG_DATA_W-1:0] deb);
    wait_drained();
    write_reg(CFG_TD_WINDOW, td);
    write_reg(CFG_HOLD_WINDOW, hold);
    write_reg(CFG_DEBOUNCE, deb);
    settings_used++;
  endtask

  // walking gait: legs lift and land at random on an advancing clock, with some noise
  task automatic run_gait(input int count, input int step_max, input int noise_pct,
                          input logic [NUM_LEGS-1:0] held_legs);
    fcdt_in_t smp;
    int       pick;
    for (int n = 0; n < count; n++) begin
      pick     = $urandom_range(0, 99);
      smp.mode = 1'($urandom_range(0, 1));
      if (pick < noise_pct) begin
        smp.sample_time_us = TIME_W'({$urandom(), $urandom()});
        smp.raw_contacts   = NUM_LEGS'($urandom());
        if (pick % 3 == 0) smp.sample_time_us = '0;
        else if (pick % 3 == 1)
          smp.sample_time_us = TIME_MAX - TIME_W'($urandom_range(0, 3));
      end else begin
        for (int leg = 0; leg < NUM_LEGS; leg++)
          if ($urandom_range(0, 3) == 0) gait_contacts[leg] = ~gait_contacts[leg];
        gait_clock         = gait_clock + TIME_W'($urandom_range(1, step_max));
        smp.sample_time_us = gait_clock;
        smp.raw_contacts   = gait_contacts;
      end
      smp.raw_contacts = smp.raw_contacts | held_legs;
      apply_sample(smp);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset registers: zero timestamps, zero-length windows, debounce of one
    settings_used = 1;
    apply_sample(sample_of('0, 6'h3F, 1'b0));
    apply_sample(sample_of('0, 6'h00, 1'b1));
    apply_sample(sample_of('0, 6'h00, 1'b0));
    apply_sample(sample_of(TIME_W'(100), 6'h3F, 1'b1));
    apply_sample(sample_of(TIME_W'(100), 6'h00, 1'b0));
    apply_sample(sample_of(TIME_W'(101), 6'h00, 1'b0));
    apply_sample(sample_of(TIME_W'(102), 6'h03, 1'b0));
    apply_sample(sample_of(TIME_W'(103), 6'h03, 1'b1));

    // short windows, debounce of three with junk in the upper data bits
    configure(16'd5, 16'd3, 16'hA503);
    write_reg(CFG_SPARE, 16'hFFFF);
    apply_sample(sample_of(TIME_W'(1000), 6'h3F, 1'b0));
    apply_sample(sample_of(TIME_W'(2000), 6'h3F, 1'b1));
    apply_sample(sample_of(TIME_W'(3000), 6'h3C, 1'b0));
    apply_sample(sample_of(TIME_W'(9000), 6'h00, 1'b0));
    apply_sample(sample_of(TIME_W'(10000), 6'h05, 1'b1));
    apply_sample(sample_of(TIME_W'(30000), 6'h00, 1'b1));
    apply_sample(sample_of(TIME_W'(30500), 6'h00, 1'b0));
    apply_sample(sample_of(TIME_MAX, 6'h3F, 1'b0));
    apply_sample(sample_of(TIME_MAX, 6'h3F, 1'b1));
    apply_sample(sample_of(TIME_MAX, 6'h00, 1'b0));
    apply_sample(sample_of(TIME_MAX - 1, 6'h2A, 1'b1));

    // sender mostly busy, receiver mostly stalled
    configure(16'd20, 16'd8, 16'd3);
    run_gait(10, 12000, 9, '0);
    configure(16'd2, 16'd1, 16'd1);
    run_gait(8, 3000, 9, '0);

    // receiver holds off while the sender keeps pushing
    tx_idle_pct = 0;
    rx_idle_pct = 13;
    configure(16'hFFFF, 16'hFFFF, 16'd0);
    pressure_req = 1'b1;
    run_gait(10, 20000, 0, '0);
    tx_idle_pct = 67;
    run_gait(10, 20000, 9, '0);
    configure(16'd0, 16'd0, 16'd2);
    run_gait(8, 50, 9, '0);

    // knock every leg out of stance before the long debounce
    gait_clock = gait_clock + TIME_W'(10);
    apply_sample(sample_of(gait_clock, 6'h3F, 1'b0));
    gait_clock = gait_clock + TIME_W'(1);
    apply_sample(sample_of(gait_clock, 6'h00, 1'b1));

    // no idling; leg 0 kept down long enough to saturate its streak
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure(16'd40, 16'd20, 16'd255);
    run_gait(256, 5000, 0, 6'b000001);

    wait_drained();
    $display("summary: %0d samples over %0d register settings, %0d leg results compared",
             samples_sent, settings_used, results_checked);
    $display("summary: phases observed %b, one receiver hold-off of %0d cycles",
             phases_seen, PRESSURE_CYCLES);
    if (error_count == 0) begin
      $display("tb_foot_contact_debounce_tracker: done, clean");
    end else begin
      $display("tb_foot_contact_debounce_tracker: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/fcdt_pkg.sv
design/fcdt_leg_unit.sv
design/foot_contact_debounce_tracker.sv
sim/fcdt_contact_checker.sv
sim/tb_foot_contact_debounce_tracker.sv
